[rtl/lmb_pkg.sv]
// ----------------------------------------------------------------------------
// lmb_pkg
// Shared types, constants and helpers for the level meter ballistics block.
// ----------------------------------------------------------------------------
package lmb_pkg;

  // Channel count and state memory addressing
  localparam int NUM_CHANNELS = 2;
  localparam int CH_ADDR_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // dB scale limits, signed Q8 dB
  localparam logic signed [15:0] DB_FLOOR = -16'sd25600;
  localparam logic signed [15:0] DB_CEIL  = 16'sd1541;

  // 20*log10(2) in Q16, times 2^8 output scale, over 2^24
  localparam logic signed [20:0] DB_PER_LOG2_Q16 = 21'sd394566;

  // Log converter pipeline: normalize, one squaring per fraction bit,
  // scale multiply, round and clamp
  localparam int LOG_SQ_STEPS = 16;
  localparam int LOG_LAT      = LOG_SQ_STEPS + 3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd3;
  localparam int CFG_DATA_W = 16;

  // Configuration reset values
  localparam logic [15:0] ATTACK_RST  = 16'd1016;
  localparam logic [15:0] RELEASE_RST = 16'd57358;
  localparam logic [7:0]  HOLD_RST    = 8'd45;
  localparam logic [7:0]  DECAY_RST   = 8'd77;

  // Input transaction payload
  typedef struct packed {
    logic [2:0]  channel;
    logic [15:0] rms_level;
    logic [15:0] peak_level;
    logic        last_channel;
  } in_item_t;

  // Output transaction payload
  typedef struct packed {
    logic [2:0]         out_channel;
    logic signed [15:0] smoothed_rms_db;
    logic signed [15:0] channel_peak_db;
    logic signed [15:0] global_peak_db;
    logic               frame_done;
  } out_item_t;

  // Held peak with its hold countdown
  typedef struct packed {
    logic signed [15:0] held;
    logic [7:0]         count;
  } hold_t;

  // One word of the per-channel state memory
  typedef struct packed {
    logic signed [15:0] rms;
    hold_t              pk;
  } chan_state_t;

  localparam chan_state_t CHAN_RST = '{rms: DB_FLOOR, pk: '{held: DB_FLOOR, count: 8'd0}};

  function automatic logic ch_in_range(input logic [2:0] ch);
    return {1'b0, ch} < 4'(NUM_CHANNELS);
  endfunction

  // Peak hold rule: capture and rearm, count down, then decay toward v
  function automatic hold_t hold_step(input logic signed [15:0] v,
                                      input hold_t              cur,
                                      input logic [7:0]         hold_frames,
                                      input logic [7:0]         decay_step);
    logic signed [16:0] dec;
    logic signed [16:0] v_ext;
    hold_t              r;
    r     = cur;
    dec   = $signed({cur.held[15], cur.held}) - $signed({9'b0, decay_step});
    v_ext = $signed({v[15], v});
    if (v >= cur.held) begin
      r.held  = v;
      r.count = hold_frames;
    end else if (cur.count != 8'd0) begin
      r.count = cur.count - 8'd1;
    end else if (v_ext > dec) begin
      r.held = v;
    end else begin
      r.held = dec[15:0];
    end
    return r;
  endfunction

endpackage

[rtl/lmb_log_db.sv]
// ----------------------------------------------------------------------------
// lmb_log_db
// Pipelined linear Q1.15 to signed Q8 dB converter, log2 by repeated squaring.
// ----------------------------------------------------------------------------
module lmb_log_db (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [15:0]        x_i,
  output logic signed [15:0] db_o
);
  import lmb_pkg::*;

  // Normalize: leading zero count and mantissa with top bit set
  logic [3:0]  nrm_sh;
  logic [15:0] nrm_m;

  always_comb begin
    nrm_sh = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (x_i[i]) begin
        nrm_sh = 4'(15 - i);
      end
    end
    nrm_m = x_i << nrm_sh;
  end

  // Pipeline registers; index 0 is the normalize stage
  logic [15:0] m_q    [LOG_SQ_STEPS+1];
  logic [15:0] f_q    [LOG_SQ_STEPS+1];
  logic [3:0]  sh_q   [LOG_SQ_STEPS+1];
  logic        zero_q [LOG_SQ_STEPS+1];

  // One squaring per stage yields one fraction bit
  logic [15:0] sq_m   [LOG_SQ_STEPS];
  logic        sq_bit [LOG_SQ_STEPS];

  always_comb begin
    logic [31:0] prod;
    for (int k = 0; k < LOG_SQ_STEPS; k++) begin
      prod      = m_q[k] * m_q[k];
      sq_bit[k] = prod[31];
      sq_m[k]   = prod[31] ? prod[31:16] : prod[30:15];
    end
  end

  // Q16 log2 and scale to dB
  logic signed [20:0] log_q16;
  logic signed [41:0] mul_q;
  logic               mul_zero_q;
  logic [4:0]         neg_sh;

  assign neg_sh  = 5'd0 - {1'b0, sh_q[LOG_SQ_STEPS]};
  assign log_q16 = $signed({neg_sh, f_q[LOG_SQ_STEPS]});

  // Round, floor shift and clamp
  logic signed [41:0] rnd;
  logic signed [17:0] db_raw;
  logic signed [15:0] db_d;
  logic signed [15:0] db_q;

  always_comb begin
    rnd    = mul_q + 42'sd8388608;
    db_raw = rnd[41:24];
    if (mul_zero_q) begin
      db_d = DB_FLOOR;
    end else if (db_raw < $signed({{2{DB_FLOOR[15]}}, DB_FLOOR})) begin
      db_d = DB_FLOOR;
    end else if (db_raw > $signed({2'b00, DB_CEIL})) begin
      db_d = DB_CEIL;
    end else begin
      db_d = db_raw[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]    <= nrm_m;
      f_q[0]    <= 16'd0;
      sh_q[0]   <= nrm_sh;
      zero_q[0] <= (x_i == 16'd0);
      for (int k = 0; k < LOG_SQ_STEPS; k++) begin
        m_q[k+1]    <= sq_m[k];
        f_q[k+1]    <= {f_q[k][14:0], sq_bit[k]};
        sh_q[k+1]   <= sh_q[k];
        zero_q[k+1] <= zero_q[k];
      end
      mul_q      <= log_q16 * DB_PER_LOG2_Q16;
      mul_zero_q <= zero_q[LOG_SQ_STEPS];
      db_q       <= db_d;
    end
  end

  assign db_o = db_q;

endmodule

[rtl/level_meter_ballistics_peak_hold_unit.sv]
// ----------------------------------------------------------------------------
// level_meter_ballistics_peak_hold_unit
// Per-channel dB meter ballistics with peak hold and a global held peak.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i): one transaction per
//   channel per meter frame, linear RMS and peak in Q1.15; last_channel marks
//   the end of a frame. Output channel (out_valid_o/out_ready_i/out_data_o):
//   exactly one result transaction per input transaction, in order.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i
//   (attack, release, hold frames, decay step); write only while idle.
//   Pipeline: the input edge loads the first of 19 dB conversion stages
//   (normalize, one squaring stage per log2 fraction bit, scale multiply
//   and rounding), then come one state read-modify-write stage and the
//   output register. Throughput: one transaction per cycle while the
//   modify stage is not blocked.
//   Channel state sits in a small synchronous memory read one stage ahead;
//   back-to-back transactions on the same channel are forwarded.
//   Reset: all channel state reads as -100 dB, countdowns zero, registers
//   take their defaults; nothing is swept, the block is ready at once.
//   Receiver stall: the output register holds; the pipeline keeps taking
//   transactions until a finished one reaches the modify stage, then stops.
// ----------------------------------------------------------------------------
module level_meter_ballistics_peak_hold_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  lmb_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output lmb_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [lmb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lmb_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import lmb_pkg::*;

  // Configuration registers
  logic [15:0] attack_q;
  logic [15:0] release_q;
  logic [7:0]  hold_q;
  logic [7:0]  decay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= ATTACK_RST;
      release_q <= RELEASE_RST;
      hold_q    <= HOLD_RST;
      decay_q   <= DECAY_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ATTACK:  attack_q  <= cfg_wdata_i;
        CFG_RELEASE: release_q <= cfg_wdata_i;
        CFG_HOLD:    hold_q    <= cfg_wdata_i[7:0];
        CFG_DECAY:   decay_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Flow control: whole pipeline advances unless the modify stage is blocked
  logic out_valid_q;
  logic m_valid_q;
  logic out_take;
  logic adv;

  assign out_take   = !out_valid_q || out_ready_i;
  assign adv        = !m_valid_q || out_take;
  assign in_ready_o = adv;

  // dB converters
  logic signed [15:0] rms_db;
  logic signed [15:0] peak_db;

  lmb_log_db u_log_rms (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (in_data_i.rms_level),
    .db_o  (rms_db)
  );

  lmb_log_db u_log_peak (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (in_data_i.peak_level),
    .db_o  (peak_db)
  );

  // Sideband pipeline matched to the converter latency
  logic       sv_q    [LOG_LAT];
  logic [2:0] sch_q   [LOG_LAT];
  logic       slast_q [LOG_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LOG_LAT; k++) begin
        sv_q[k] <= 1'b0;
      end
    end else if (adv) begin
      sv_q[0] <= in_valid_i;
      for (int k = 1; k < LOG_LAT; k++) begin
        sv_q[k] <= sv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sch_q[0]   <= in_data_i.channel;
      slast_q[0] <= in_data_i.last_channel;
      for (int k = 1; k < LOG_LAT; k++) begin
        sch_q[k]   <= sch_q[k-1];
        slast_q[k] <= slast_q[k-1];
      end
    end
  end

  // Modify stage registers
  logic [2:0]         m_ch_q;
  logic               m_last_q;
  logic signed [15:0] m_rms_q;
  logic signed [15:0] m_peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= sv_q[LOG_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_ch_q   <= sch_q[LOG_LAT-1];
      m_last_q <= slast_q[LOG_LAT-1];
      m_rms_q  <= rms_db;
      m_peak_q <= peak_db;
    end
  end

  // Channel state memory: read one stage ahead, write back from modify stage
  chan_state_t          mem_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] ent_valid_q;
  chan_state_t          rd_data_q;
  logic                 rd_ent_valid_q;
  logic                 byp_hit_q;
  chan_state_t          byp_data_q;

  logic [CH_ADDR_W-1:0] rd_addr;
  logic                 rd_req;
  logic [CH_ADDR_W-1:0] wr_addr;
  logic                 wr_en;
  chan_state_t          wr_data;
  logic                 m_in_range;

  assign rd_addr    = sch_q[LOG_LAT-1][CH_ADDR_W-1:0];
  assign rd_req     = sv_q[LOG_LAT-1] && ch_in_range(sch_q[LOG_LAT-1]);
  assign m_in_range = ch_in_range(m_ch_q);
  assign wr_addr    = m_ch_q[CH_ADDR_W-1:0];
  assign wr_en      = m_valid_q && out_take && m_in_range;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_data_q <= mem_q[rd_addr];
    end
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // Entry valid bits and same-edge write forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q    <= '0;
      rd_ent_valid_q <= 1'b0;
      byp_hit_q      <= 1'b0;
    end else begin
      if (adv) begin
        rd_ent_valid_q <= ent_valid_q[rd_addr];
        byp_hit_q      <= wr_en && rd_req && (rd_addr == wr_addr);
      end
      if (wr_en) begin
        ent_valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byp_data_q <= wr_data;
    end
  end

  // Read-modify-write of one channel's state
  chan_state_t        cur;
  logic signed [15:0] prev_rms;
  logic [15:0]        coef;
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic signed [33:0] adj;
  logic signed [17:0] rms_sum;

  always_comb begin
    if (byp_hit_q) begin
      cur = byp_data_q;
    end else if (rd_ent_valid_q) begin
      cur = rd_data_q;
    end else begin
      cur = CHAN_RST;
    end
    prev_rms = cur.rms;
    coef     = (m_rms_q > prev_rms) ? attack_q : release_q;
    diff     = $signed({prev_rms[15], prev_rms}) - $signed({m_rms_q[15], m_rms_q});
    prod     = $signed({1'b0, coef}) * diff;
    adj      = prod + 34'sd32768;
    rms_sum  = $signed({{2{m_rms_q[15]}}, m_rms_q}) + adj[33:16];
    wr_data.rms = rms_sum[15:0];
    wr_data.pk  = hold_step(m_peak_q, cur.pk, hold_q, decay_q);
  end

  // Frame maximum and global held peak
  logic signed [15:0] frame_max_q;
  hold_t              global_q;
  logic signed [15:0] fm_new;
  hold_t              global_d;

  always_comb begin
    fm_new   = (m_peak_q > frame_max_q) ? m_peak_q : frame_max_q;
    global_d = m_last_q ? hold_step(fm_new, global_q, hold_q, decay_q) : global_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_max_q    <= DB_FLOOR;
      global_q.held  <= DB_FLOOR;
      global_q.count <= 8'd0;
    end else if (m_valid_q && out_take) begin
      frame_max_q <= m_last_q ? DB_FLOOR : fm_new;
      global_q    <= global_d;
    end
  end

  // Output register
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_q.out_channel     <= m_ch_q;
      out_q.smoothed_rms_db <= m_in_range ? wr_data.rms : DB_FLOOR;
      out_q.channel_peak_db <= m_in_range ? wr_data.pk.held : DB_FLOOR;
      out_q.global_peak_db  <= global_d.held;
      out_q.frame_done      <= m_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_accept_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> sv_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && m_valid_q) |-> !in_ready_o)
    else $error("input taken while modify stage is blocked");

  a_frame_max_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_take && m_last_q) |=> (frame_max_q == DB_FLOOR))
    else $error("frame maximum not cleared after last channel");

  a_out_of_range_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_take && !m_in_range) |=>
      (out_valid_o && out_data_o.smoothed_rms_db == DB_FLOOR &&
       out_data_o.channel_peak_db == DB_FLOOR))
    else $error("out-of-range channel result not at floor");

  a_no_write_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (m_valid_q && m_in_range && adv))
    else $error("state write without a transaction in the modify stage");

endmodule
